[sv/bcrm_pkg.sv]
// Package for the byte counter rate meter: microcode types, constants and the control store.
package bcrm_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_PRIMED = 2'd0;
   localparam logic [1:0] STATUS_SKIP   = 2'd1;
   localparam logic [1:0] STATUS_RATE   = 2'd2;
   localparam logic [1:0] STATUS_ERROR  = 2'd3;

   localparam int unsigned STEP_W = 4;
   localparam int unsigned CNT_W  = 7;

   localparam logic [CNT_W-1:0] RATE_DIV_STEPS = CNT_W'(32);
   localparam logic [CNT_W-1:0] AVG_DIV_STEPS  = CNT_W'(64);

   typedef logic [STEP_W-1:0] step_type;

   // Program addresses
   localparam step_type ST_IDLE      = 4'd0;
   localparam step_type ST_CHK_OK    = 4'd1;
   localparam step_type ST_CHK_PRIME = 4'd2;
   localparam step_type ST_CHK_TIME  = 4'd3;
   localparam step_type ST_LD_RATE   = 4'd4;
   localparam step_type ST_DIV_RATE  = 4'd5;
   localparam step_type ST_UPDATE    = 4'd6;
   localparam step_type ST_CHK_CNT   = 4'd7;
   localparam step_type ST_LD_AVG    = 4'd8;
   localparam step_type ST_DIV_AVG   = 4'd9;
   localparam step_type ST_SAVE_AVG  = 4'd10;
   localparam step_type ST_EMIT_RATE = 4'd11;
   localparam step_type ST_PRIME     = 4'd12;
   localparam step_type ST_EMIT_PRM  = 4'd13;
   localparam step_type ST_EMIT_ERR  = 4'd14;
   localparam step_type ST_EMIT_SKIP = 4'd15;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PRIME,
      OP_LOAD_RATE,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_LOAD_AVG,
      OP_SAVE_AVG,
      OP_EMIT
   } op_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_NO_REQ,
      C_NOT_OK,
      C_NOT_PRIMED,
      C_BAD_TIME,
      C_DIV_MORE,
      C_NO_SAMPLES,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type     op;
      cond_type   cond;
      step_type   target;
      logic       done;     // fall through to idle instead of the next step
      logic [1:0] status;
   } uword_type;

   // Control store
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{op: OP_NONE, cond: C_NEVER, target: ST_IDLE, done: 1'b0, status: STATUS_RATE};
      case (step)
         ST_IDLE:      begin w.cond = C_NO_REQ;     w.target = ST_IDLE;      end
         ST_CHK_OK:    begin w.cond = C_NOT_OK;     w.target = ST_EMIT_ERR;  end
         ST_CHK_PRIME: begin w.cond = C_NOT_PRIMED; w.target = ST_PRIME;     end
         ST_CHK_TIME:  begin w.cond = C_BAD_TIME;   w.target = ST_EMIT_SKIP; end
         ST_LD_RATE:   begin w.op = OP_LOAD_RATE; end
         ST_DIV_RATE:  begin
            w.op = OP_DIV_STEP; w.cond = C_DIV_MORE; w.target = ST_DIV_RATE;
         end
         ST_UPDATE:    begin w.op = OP_UPDATE; end
         ST_CHK_CNT:   begin w.cond = C_NO_SAMPLES; w.target = ST_EMIT_RATE; end
         ST_LD_AVG:    begin w.op = OP_LOAD_AVG; end
         ST_DIV_AVG:   begin
            w.op = OP_DIV_STEP; w.cond = C_DIV_MORE; w.target = ST_DIV_AVG;
         end
         ST_SAVE_AVG:  begin w.op = OP_SAVE_AVG; end
         ST_EMIT_RATE: begin
            w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = ST_EMIT_RATE;
            w.done = 1'b1; w.status = STATUS_RATE;
         end
         ST_PRIME:     begin w.op = OP_PRIME; w.cond = C_NEVER; end
         ST_EMIT_PRM:  begin
            w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = ST_EMIT_PRM;
            w.done = 1'b1; w.status = STATUS_PRIMED;
         end
         ST_EMIT_ERR:  begin
            w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = ST_EMIT_ERR;
            w.done = 1'b1; w.status = STATUS_ERROR;
         end
         ST_EMIT_SKIP: begin
            w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = ST_EMIT_SKIP;
            w.done = 1'b1; w.status = STATUS_SKIP;
         end
         default:      begin w.done = 1'b1; end
      endcase
      return w;
   endfunction

endpackage

[sv/byte_counter_rate_meter.sv]
// Byte counter rate meter: microcoded sequencer with a two-lane shared-divisor divider.
//
// Takes one counter snapshot at a time and returns one result per snapshot. A read
// error goes straight to its result, priming after the priming check, a skipped
// sample after the time check, and a computed rate after the divider: receive and
// transmit quotients run side by side through a radix-2 restoring divider (one
// quotient bit per cycle, one lane per channel sharing the divisor), 32 quotient bits
// for the rates and 64 for the averages. The input side reopens once the result is
// loaded into the output register, so a pending result does not block the next
// snapshot. Min, max and average outputs read zero while the sample count is zero.
module byte_counter_rate_meter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_read_ok,
   input  logic [31:0] req_rx_byte_count,
   input  logic [31:0] req_tx_byte_count,
   input  logic [31:0] req_timestamp_sec,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_rx_rate,
   output logic [31:0] rsp_tx_rate,
   output logic [31:0] rsp_total_rate,
   output logic [31:0] rsp_rx_rate_min,
   output logic [31:0] rsp_rx_rate_max,
   output logic [31:0] rsp_rx_rate_avg,
   output logic [31:0] rsp_tx_rate_min,
   output logic [31:0] rsp_tx_rate_max,
   output logic [31:0] rsp_tx_rate_avg,
   output logic [31:0] rsp_rate_samples
);

   // Sequencer
   bcrm_pkg::step_type  step_ff, step_in;
   bcrm_pkg::uword_type uw;
   logic                cond_hit;

   // Captured snapshot
   logic        ok_ff;
   logic [31:0] rx_ff, tx_ff, now_ff;

   // Measurement state
   logic        primed_ff;
   logic [31:0] prev_rx_ff, prev_tx_ff, prev_time_ff;
   logic [31:0] last_rx_ff, last_tx_ff, last_total_ff;
   logic [31:0] min_rx_ff, max_rx_ff, min_tx_ff, max_tx_ff;
   logic [63:0] sum_rx_ff, sum_tx_ff;
   logic [31:0] samples_ff;
   logic [31:0] avg_rx_ff, avg_tx_ff;

   // Divider lanes
   logic [31:0]               div_ff;
   logic [bcrm_pkg::CNT_W-1:0] cnt_ff;
   logic [31:0]               rem_rx_ff, rem_tx_ff;
   logic [63:0]               q_rx_ff, q_tx_ff;
   logic [32:0]               t_rx, t_tx, s_rx, s_tx;
   logic                      ge_rx, ge_tx;

   // Output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_rx_rate_ff, rsp_tx_rate_ff, rsp_total_rate_ff;
   logic [31:0] rsp_rx_min_ff, rsp_rx_max_ff, rsp_rx_avg_ff;
   logic [31:0] rsp_tx_min_ff, rsp_tx_max_ff, rsp_tx_avg_ff;
   logic [31:0] rsp_samples_ff;

   logic [31:0] elapsed;
   logic        bad_time, out_busy, req_xfer, have_stats;
   logic [31:0] rate_rx, rate_tx;

   assign uw       = bcrm_pkg::ucode(step_ff);
   assign req_stall = (step_ff != bcrm_pkg::ST_IDLE);
   assign req_xfer = req_valid && !req_stall;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign elapsed  = now_ff - prev_time_ff;
   assign bad_time = (elapsed == 32'd0) || elapsed[31];
   assign rate_rx  = q_rx_ff[31:0];
   assign rate_tx  = q_tx_ff[31:0];
   assign have_stats = (samples_ff != 32'd0);

   // One restoring step per lane
   assign t_rx  = {rem_rx_ff, q_rx_ff[63]};
   assign t_tx  = {rem_tx_ff, q_tx_ff[63]};
   assign s_rx  = t_rx - {1'b0, div_ff};
   assign s_tx  = t_tx - {1'b0, div_ff};
   assign ge_rx = (t_rx >= {1'b0, div_ff});
   assign ge_tx = (t_tx >= {1'b0, div_ff});

   // Jump condition
   always_comb begin
      case (uw.cond)
         bcrm_pkg::C_NEVER:      cond_hit = 1'b0;
         bcrm_pkg::C_NO_REQ:     cond_hit = !req_valid;
         bcrm_pkg::C_NOT_OK:     cond_hit = !ok_ff;
         bcrm_pkg::C_NOT_PRIMED: cond_hit = !primed_ff;
         bcrm_pkg::C_BAD_TIME:   cond_hit = bad_time;
         bcrm_pkg::C_DIV_MORE:   cond_hit = (cnt_ff != bcrm_pkg::CNT_W'(1));
         bcrm_pkg::C_NO_SAMPLES: cond_hit = !have_stats;
         bcrm_pkg::C_OUT_BUSY:   cond_hit = out_busy;
         default:                cond_hit = 1'b0;
      endcase
   end

   // Next step
   always_comb begin
      if (cond_hit) begin
         step_in = uw.target;
      end else if (uw.done) begin
         step_in = bcrm_pkg::ST_IDLE;
      end else begin
         step_in = step_ff + bcrm_pkg::step_type'(1);
      end
   end

   // Sequencer, datapath and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= bcrm_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         primed_ff     <= 1'b0;
         prev_rx_ff    <= '0;
         prev_tx_ff    <= '0;
         prev_time_ff  <= '0;
         last_rx_ff    <= '0;
         last_tx_ff    <= '0;
         last_total_ff <= '0;
         min_rx_ff     <= '1;
         max_rx_ff     <= '0;
         min_tx_ff     <= '1;
         max_tx_ff     <= '0;
         sum_rx_ff     <= '0;
         sum_tx_ff     <= '0;
         samples_ff    <= '0;
         avg_rx_ff     <= '0;
         avg_tx_ff     <= '0;
      end else begin
         step_ff <= step_in;

         // snapshot capture
         if (req_xfer) begin
            ok_ff  <= req_read_ok;
            rx_ff  <= req_rx_byte_count;
            tx_ff  <= req_tx_byte_count;
            now_ff <= req_timestamp_sec;
         end

         // result taken with nothing new to load
         if (rsp_valid_ff && !rsp_stall && (uw.op != bcrm_pkg::OP_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (uw.op)
            bcrm_pkg::OP_PRIME: begin
               primed_ff     <= 1'b1;
               prev_rx_ff    <= rx_ff;
               prev_tx_ff    <= tx_ff;
               prev_time_ff  <= now_ff;
               last_rx_ff    <= '0;
               last_tx_ff    <= '0;
               last_total_ff <= '0;
            end
            bcrm_pkg::OP_LOAD_RATE: begin
               div_ff    <= elapsed;
               cnt_ff    <= bcrm_pkg::RATE_DIV_STEPS;
               rem_rx_ff <= '0;
               rem_tx_ff <= '0;
               q_rx_ff   <= {rx_ff - prev_rx_ff, 32'd0};
               q_tx_ff   <= {tx_ff - prev_tx_ff, 32'd0};
            end
            bcrm_pkg::OP_DIV_STEP: begin
               cnt_ff    <= cnt_ff - bcrm_pkg::CNT_W'(1);
               rem_rx_ff <= ge_rx ? s_rx[31:0] : t_rx[31:0];
               rem_tx_ff <= ge_tx ? s_tx[31:0] : t_tx[31:0];
               q_rx_ff   <= {q_rx_ff[62:0], ge_rx};
               q_tx_ff   <= {q_tx_ff[62:0], ge_tx};
            end
            bcrm_pkg::OP_UPDATE: begin
               if (rate_rx < min_rx_ff) min_rx_ff <= rate_rx;
               if (rate_rx > max_rx_ff) max_rx_ff <= rate_rx;
               if (rate_tx < min_tx_ff) min_tx_ff <= rate_tx;
               if (rate_tx > max_tx_ff) max_tx_ff <= rate_tx;
               sum_rx_ff     <= sum_rx_ff + {32'd0, rate_rx};
               sum_tx_ff     <= sum_tx_ff + {32'd0, rate_tx};
               samples_ff    <= samples_ff + 32'd1;
               prev_rx_ff    <= rx_ff;
               prev_tx_ff    <= tx_ff;
               prev_time_ff  <= now_ff;
               last_rx_ff    <= rate_rx;
               last_tx_ff    <= rate_tx;
               last_total_ff <= rate_rx + rate_tx;
            end
            bcrm_pkg::OP_LOAD_AVG: begin
               div_ff    <= samples_ff;
               cnt_ff    <= bcrm_pkg::AVG_DIV_STEPS;
               rem_rx_ff <= '0;
               rem_tx_ff <= '0;
               q_rx_ff   <= sum_rx_ff;
               q_tx_ff   <= sum_tx_ff;
            end
            bcrm_pkg::OP_SAVE_AVG: begin
               avg_rx_ff <= rate_rx;
               avg_tx_ff <= rate_tx;
            end
            bcrm_pkg::OP_EMIT: begin
               // load the output register once it is free
               if (!out_busy) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= uw.status;
                  rsp_rx_rate_ff    <= last_rx_ff;
                  rsp_tx_rate_ff    <= last_tx_ff;
                  rsp_total_rate_ff <= last_total_ff;
                  rsp_rx_min_ff     <= have_stats ? min_rx_ff : 32'd0;
                  rsp_rx_max_ff     <= have_stats ? max_rx_ff : 32'd0;
                  rsp_rx_avg_ff     <= have_stats ? avg_rx_ff : 32'd0;
                  rsp_tx_min_ff     <= have_stats ? min_tx_ff : 32'd0;
                  rsp_tx_max_ff     <= have_stats ? max_tx_ff : 32'd0;
                  rsp_tx_avg_ff     <= have_stats ? avg_tx_ff : 32'd0;
                  rsp_samples_ff    <= samples_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_rx_rate      = rsp_rx_rate_ff;
   assign rsp_tx_rate      = rsp_tx_rate_ff;
   assign rsp_total_rate   = rsp_total_rate_ff;
   assign rsp_rx_rate_min  = rsp_rx_min_ff;
   assign rsp_rx_rate_max  = rsp_rx_max_ff;
   assign rsp_rx_rate_avg  = rsp_rx_avg_ff;
   assign rsp_tx_rate_min  = rsp_tx_min_ff;
   assign rsp_tx_rate_max  = rsp_tx_max_ff;
   assign rsp_tx_rate_avg  = rsp_tx_avg_ff;
   assign rsp_rate_samples = rsp_samples_ff;

   // The divider never steps with an exhausted count
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (uw.op == bcrm_pkg::OP_DIV_STEP) |-> (cnt_ff != '0))
      else $error("divider stepped with zero count");

   // Partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (uw.op == bcrm_pkg::OP_DIV_STEP) |-> (rem_rx_ff < div_ff && rem_tx_ff < div_ff))
      else $error("divider remainder out of range");

   // Extremes stay ordered once a rate has been taken
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (samples_ff != 32'd0) |-> (min_rx_ff <= max_rx_ff && min_tx_ff <= max_tx_ff))
      else $error("min above max");

   // A rate result only follows a primed reference
   a_rate_primed: assert property (@(posedge clock) disable iff (reset)
      (uw.op == bcrm_pkg::OP_UPDATE) |-> primed_ff)
      else $error("rate taken before priming");

endmodule
